// ----- src/sbet_pkg.sv -----
// sbet_pkg: shared types, codes and constants for the sensor bank edge tracker
// no dependencies; used by sensor_bank_edge_tracker
`default_nettype none

package sbet_pkg;

    // default sizes
    localparam int BANKS_DEF       = 5;
    localparam int WATCH_SLOTS_DEF = 5;

    // slot tag registers
    localparam int NUM_TAG_REGS = 5;
    localparam int TAG_W        = 7;
    localparam logic [TAG_W-1:0] TAG_RESET [NUM_TAG_REGS] =
        '{7'd1, 7'd54, 7'd55, 7'd58, 7'd77};

    // field widths
    localparam int BANK_W  = 3;
    localparam int POS_W   = 4;
    localparam int WORD_W  = 16;
    localparam int IDX_W   = 7;
    localparam int SLOT_W  = 3;
    localparam int REQ_W   = 8;
    localparam int TICK_W  = 32;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // operation codes
    localparam logic OP_REPORT   = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    // result kinds
    localparam logic KIND_TRIGGER = 1'b0;
    localparam logic KIND_HIT     = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RPT_RD,
        ST_TRIG,
        ST_CHK_RD,
        ST_CHK_ST,
        ST_CHK_EV,
        ST_DONE
    } t_state;

    // one result item without its last flag
    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  sensor_index;
        logic [SLOT_W-1:0] watcher_slot;
        logic [REQ_W-1:0]  hit_requester;
        logic [TICK_W-1:0] hit_tick;
    } t_result;

endpackage

`default_nettype wire

// ----- src/sbet_ram.sv -----
// sbet_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sbet_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 5,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- src/sensor_bank_edge_tracker.sv -----
// sensor_bank_edge_tracker: top level, sequencer around the status and watch rams
// depends on sbet_pkg and sbet_ram
`default_nettype none

//  channel   direction  handshake          payload
//  input     in         i_valid / o_ready  i_operation .. i_sensor_position
//  result    out        o_valid / i_ready  o_kind .. o_last
//  config    in         psel/penable/...   paddr, pwdata, prdata (slot tags)
//
//  one item at a time: accept, the status read of a report, a trigger step per
//  off-to-on edge and one more with no edge left, then per watch slot a skip
//  if disarmed or, if armed, watch ram read, status ram read and evaluate, and
//  a step to close the item
//  reset: synchronous, active low; clears control state, bank valid bits,
//  armed bits and restores the slot tags; a stalled result only holds the
//  sequencer when another result needs the output register

module sensor_bank_edge_tracker #(
    parameter int BANKS       = sbet_pkg::BANKS_DEF,
    parameter int WATCH_SLOTS = sbet_pkg::WATCH_SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input item
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_operation,
    input  wire logic [sbet_pkg::BANK_W-1:0]  i_bank,
    input  wire logic [7:0]                   i_high_byte,
    input  wire logic [7:0]                   i_low_byte,
    input  wire logic                         i_end_of_scan,
    input  wire logic [sbet_pkg::TICK_W-1:0]  i_tick,
    input  wire logic [sbet_pkg::TAG_W-1:0]   i_watcher_tag,
    input  wire logic [sbet_pkg::REQ_W-1:0]   i_requester,
    input  wire logic [sbet_pkg::POS_W-1:0]   i_sensor_position,
    // result item
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic                              o_kind,
    output logic      [sbet_pkg::IDX_W-1:0]   o_sensor_index,
    output logic      [sbet_pkg::SLOT_W-1:0]  o_watcher_slot,
    output logic      [sbet_pkg::REQ_W-1:0]   o_hit_requester,
    output logic      [sbet_pkg::TICK_W-1:0]  o_hit_tick,
    output logic                              o_last,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sbet_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sbet_pkg::PDATA_W-1:0] pwdata,
    output logic      [sbet_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);

    localparam int BW  = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int SW  = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
    localparam int WRW = sbet_pkg::IDX_W + sbet_pkg::REQ_W;   // watch ram word
    localparam logic [SW-1:0] LAST_SLOT = SW'(WATCH_SLOTS - 1);

    // ---------------- slot tag registers ----------------
    logic [sbet_pkg::TAG_W-1:0] r_tag [WATCH_SLOTS];
    logic [2:0]                 cfg_idx;
    logic                       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite;

    for (genvar g = 0; g < WATCH_SLOTS; g++) begin : g_tag
        if (g < sbet_pkg::NUM_TAG_REGS) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tag[g] <= sbet_pkg::TAG_RESET[g];
                end else if (cfg_wr && cfg_idx == 3'(g)) begin
                    r_tag[g] <= pwdata[sbet_pkg::TAG_W-1:0];
                end
            end
        end else begin : g_fixed
            // slots past the register list keep tag zero
            assign r_tag[g] = '0;
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        for (int k = 0; k < WATCH_SLOTS; k++) begin
            if (k < sbet_pkg::NUM_TAG_REGS && cfg_idx == 3'(k)) begin
                prdata = {{(sbet_pkg::PDATA_W - sbet_pkg::TAG_W){1'b0}}, r_tag[k]};
            end
        end
    end

    // ---------------- state ----------------
    sbet_pkg::t_state                r_state, n_state;
    logic [BW-1:0]                   r_bank, n_bank;        // bank of the report
    logic [sbet_pkg::WORD_W-1:0]     r_word, n_word;        // new status word
    logic                            r_eos, n_eos;
    logic [sbet_pkg::TICK_W-1:0]     r_tick, n_tick;
    logic [sbet_pkg::WORD_W-1:0]     r_edge, n_edge;        // off-to-on edges left
    logic [SW-1:0]                   r_slot, n_slot;        // slot under check
    logic [WATCH_SLOTS-1:0]          r_armed, n_armed;
    logic [BANKS-1:0]                r_bank_vld, n_bank_vld; // bank written since reset
    logic                            r_ltv, n_ltv;          // last trigger valid
    logic [sbet_pkg::IDX_W-1:0]      r_lti, n_lti;          // last trigger index
    sbet_pkg::t_result               r_pend, n_pend;        // result held back for last
    logic                            r_pvalid, n_pvalid;
    sbet_pkg::t_result               r_out, n_out;          // output register
    logic                            r_olast, n_olast;
    logic                            r_ovalid, n_ovalid;

    // ram ports
    logic                            st_we;
    logic [BW-1:0]                   st_waddr, st_raddr;
    logic [sbet_pkg::WORD_W-1:0]     st_rdata;
    logic                            wt_we;
    logic [SW-1:0]                   wt_waddr;
    logic [WRW-1:0]                  wt_wdata, wt_rdata;

    // decoded helpers
    logic                            in_acc;
    logic                            bank_ok;
    logic                            rep_live;             // report to a valid bank with a nonzero word
    logic                            tag_hit;
    logic [SW-1:0]                   tag_slot;
    logic                            out_free;
    logic                            emit_ok;
    logic                            edge_any;
    logic [sbet_pkg::POS_W-1:0]      edge_pos;
    logic [sbet_pkg::IDX_W-1:0]      edge_idx;
    logic                            edge_dup;             // same sensor as last trigger
    logic [sbet_pkg::IDX_W-1:0]      w_sens;
    logic [sbet_pkg::REQ_W-1:0]      w_req;
    logic [BW-1:0]                   w_bank;
    logic                            w_on;
    logic                            slot_armed;

    assign in_acc   = i_valid & o_ready;
    assign bank_ok  = {1'b0, i_bank} < 4'(BANKS);
    assign rep_live = bank_ok && ({i_high_byte, i_low_byte} != '0);
    assign out_free = !r_ovalid || i_ready;
    // a new result may be produced if nothing is held back or it can move on
    assign emit_ok  = !r_pvalid || out_free;

    // lowest numbered slot whose tag matches
    always_comb begin
        tag_hit  = 1'b0;
        tag_slot = '0;
        for (int k = 0; k < WATCH_SLOTS; k++) begin
            if (!tag_hit && r_tag[k] == i_watcher_tag) begin
                tag_hit  = 1'b1;
                tag_slot = SW'(k);
            end
        end
    end

    // next edge in position order: position 0 is bit 15 of the word
    always_comb begin
        edge_any = 1'b0;
        edge_pos = '0;
        for (int k = sbet_pkg::WORD_W - 1; k >= 0; k--) begin
            if (!edge_any && r_edge[k]) begin
                edge_any = 1'b1;
                edge_pos = 4'(sbet_pkg::WORD_W - 1 - k);
            end
        end
    end

    assign edge_idx = {3'(r_bank), edge_pos};
    assign edge_dup = r_ltv && (r_lti == edge_idx);

    // watch ram word of the slot under check
    assign w_sens     = wt_rdata[WRW-1 -: sbet_pkg::IDX_W];
    assign w_req      = wt_rdata[sbet_pkg::REQ_W-1:0];
    // bank field sits above the position; armed slots always hold a valid bank
    assign w_bank     = w_sens[sbet_pkg::POS_W +: BW];
    // bit 15 - position, which is the inverted position
    assign w_on       = r_bank_vld[w_bank] & st_rdata[~w_sens[sbet_pkg::POS_W-1:0]];
    assign slot_armed = r_armed[r_slot];

    assign o_ready = (r_state == sbet_pkg::ST_IDLE);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbet_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_operation == sbet_pkg::OP_REGISTER) begin
                        n_state = sbet_pkg::ST_CHK_RD;
                    end else if (rep_live) begin
                        n_state = sbet_pkg::ST_RPT_RD;
                    end else if (i_end_of_scan) begin
                        n_state = sbet_pkg::ST_CHK_RD;
                    end else begin
                        n_state = sbet_pkg::ST_DONE;
                    end
                end
            end
            sbet_pkg::ST_RPT_RD: begin
                n_state = sbet_pkg::ST_TRIG;
            end
            sbet_pkg::ST_TRIG: begin
                if (!edge_any) begin
                    n_state = r_eos ? sbet_pkg::ST_CHK_RD : sbet_pkg::ST_DONE;
                end
            end
            sbet_pkg::ST_CHK_RD: begin
                if (slot_armed) begin
                    n_state = sbet_pkg::ST_CHK_ST;
                end else if (r_slot == LAST_SLOT) begin
                    n_state = sbet_pkg::ST_DONE;
                end
            end
            sbet_pkg::ST_CHK_ST: begin
                n_state = sbet_pkg::ST_CHK_EV;
            end
            sbet_pkg::ST_CHK_EV: begin
                if (!w_on || emit_ok) begin
                    n_state = (r_slot == LAST_SLOT) ? sbet_pkg::ST_DONE
                                                    : sbet_pkg::ST_CHK_RD;
                end
            end
            sbet_pkg::ST_DONE: begin
                if (!r_pvalid || out_free) begin
                    n_state = sbet_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sbet_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath and ram control ----------------
    always_comb begin
        n_bank     = r_bank;
        n_word     = r_word;
        n_eos      = r_eos;
        n_tick     = r_tick;
        n_edge     = r_edge;
        n_slot     = r_slot;
        n_armed    = r_armed;
        n_bank_vld = r_bank_vld;
        n_ltv      = r_ltv;
        n_lti      = r_lti;
        n_pend     = r_pend;
        n_pvalid   = r_pvalid;
        n_out      = r_out;
        n_olast    = r_olast;
        n_ovalid   = r_ovalid & ~i_ready;

        st_we    = 1'b0;
        st_waddr = r_bank;
        st_raddr = w_bank;
        wt_we    = 1'b0;
        wt_waddr = tag_slot;
        wt_wdata = {i_bank, i_sensor_position, i_requester};

        case (r_state)
            sbet_pkg::ST_IDLE: begin
                // status read of the reported bank goes out now
                st_raddr = i_bank[BW-1:0];
                if (in_acc) begin
                    n_bank = i_bank[BW-1:0];
                    n_word = {i_high_byte, i_low_byte};
                    n_eos  = i_end_of_scan;
                    n_tick = i_tick;
                    n_slot = '0;
                    if (i_operation == sbet_pkg::OP_REGISTER && bank_ok && tag_hit) begin
                        wt_we             = 1'b1;
                        n_armed[tag_slot] = 1'b1;
                    end
                end
            end
            sbet_pkg::ST_RPT_RD: begin
                // old status is zero for a bank never written
                n_edge = r_word & ~(r_bank_vld[r_bank] ? st_rdata : '0);
                st_we  = 1'b1;
                n_bank_vld[r_bank] = 1'b1;
            end
            sbet_pkg::ST_TRIG: begin
                if (edge_any) begin
                    if (edge_dup) begin
                        n_edge[~edge_pos] = 1'b0;
                    end else if (emit_ok) begin
                        n_edge[~edge_pos] = 1'b0;
                        n_ltv = 1'b1;
                        n_lti = edge_idx;
                        if (r_pvalid) begin
                            n_out    = r_pend;
                            n_olast  = 1'b0;
                            n_ovalid = 1'b1;
                        end
                        n_pvalid = 1'b1;
                        n_pend   = '{kind: sbet_pkg::KIND_TRIGGER, sensor_index: edge_idx,
                                     watcher_slot: '0, hit_requester: '0, hit_tick: '0};
                    end
                end
            end
            sbet_pkg::ST_CHK_RD: begin
                if (!slot_armed && r_slot != LAST_SLOT) begin
                    n_slot = r_slot + 1'b1;
                end
            end
            sbet_pkg::ST_CHK_ST: begin
                // watch word is in; status read of its bank goes out
            end
            sbet_pkg::ST_CHK_EV: begin
                if (w_on && emit_ok) begin
                    n_armed[r_slot] = 1'b0;
                    if (r_pvalid) begin
                        n_out    = r_pend;
                        n_olast  = 1'b0;
                        n_ovalid = 1'b1;
                    end
                    n_pvalid = 1'b1;
                    n_pend   = '{kind: sbet_pkg::KIND_HIT, sensor_index: w_sens,
                                 watcher_slot: 3'(r_slot), hit_requester: w_req,
                                 hit_tick: r_tick};
                end
                if ((!w_on || emit_ok) && r_slot != LAST_SLOT) begin
                    n_slot = r_slot + 1'b1;
                end
            end
            sbet_pkg::ST_DONE: begin
                // the held-back result is the final one of the item
                if (r_pvalid && out_free) begin
                    n_out    = r_pend;
                    n_olast  = 1'b1;
                    n_ovalid = 1'b1;
                    n_pvalid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sbet_pkg::ST_IDLE;
            r_armed    <= '0;
            r_bank_vld <= '0;
            r_ltv      <= 1'b0;
            r_lti      <= '0;
            r_pvalid   <= 1'b0;
            r_ovalid   <= 1'b0;
            r_slot     <= '0;
        end else begin
            r_state    <= n_state;
            r_armed    <= n_armed;
            r_bank_vld <= n_bank_vld;
            r_ltv      <= n_ltv;
            r_lti      <= n_lti;
            r_pvalid   <= n_pvalid;
            r_ovalid   <= n_ovalid;
            r_slot     <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bank  <= n_bank;
        r_word  <= n_word;
        r_eos   <= n_eos;
        r_tick  <= n_tick;
        r_edge  <= n_edge;
        r_pend  <= n_pend;
        r_out   <= n_out;
        r_olast <= n_olast;
    end

    // ---------------- memories ----------------
    // sensor status, one 16-bit word per bank
    sbet_ram #(
        .WIDTH (sbet_pkg::WORD_W),
        .DEPTH (BANKS)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (r_word),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // watched sensor and requester per slot
    sbet_ram #(
        .WIDTH (WRW),
        .DEPTH (WATCH_SLOTS)
    ) u_watch_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (r_slot),
        .o_rdata (wt_rdata)
    );

    // ---------------- outputs ----------------
    assign o_valid         = r_ovalid;
    assign o_kind          = r_out.kind;
    assign o_sensor_index  = r_out.sensor_index;
    assign o_watcher_slot  = r_out.watcher_slot;
    assign o_hit_requester = r_out.hit_requester;
    assign o_hit_tick      = r_out.hit_tick;
    assign o_last          = r_olast;

endmodule

`default_nettype wire
